>>> rtl/cle_pkg.sv
package cle_pkg;

	// default ring depth
	localparam int unsigned BUF_DEPTH_DEF = 128;

	// control keys
	localparam logic [7:0] KEY_NUL   = 8'h00;
	localparam logic [7:0] KEY_EOF   = 8'h04;
	localparam logic [7:0] KEY_BS    = 8'h08;
	localparam logic [7:0] KEY_LF    = 8'h0A;
	localparam logic [7:0] KEY_CR    = 8'h0D;
	localparam logic [7:0] KEY_TABLE = 8'h0F;
	localparam logic [7:0] KEY_DUMP  = 8'h10;
	localparam logic [7:0] KEY_KILL  = 8'h15;
	localparam logic [7:0] KEY_DEL   = 8'h7F;

	localparam logic [7:0] ERASE_MAX = 8'hFF;

	// register map (index = paddr[3:2])
	localparam logic [1:0] REG_ECHO_ENABLE    = 2'd0;
	localparam logic [1:0] REG_LINE_BUFFERED  = 2'd1;
	localparam logic [1:0] REG_BACKSPACE_EDIT = 2'd2;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		ECHO_NONE  = 2'd0,
		ECHO_CHAR  = 2'd1,
		ECHO_ERASE = 2'd2
	} echo_kind_t;

	typedef enum logic [1:0] {
		RD_NONE  = 2'd0,
		RD_CHAR  = 2'd1,
		RD_EMPTY = 2'd2,
		RD_EOF   = 2'd3
	} read_status_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_KILL = 3'b100
	} seq_state_t;

endpackage

>>> rtl/console_line_editor_core.sv
// Canonical line-input buffer. A request is taken when start is high and busy is low;
// operation selects a key request or a read request. Each request gives exactly one
// result, shown for one cycle with done high; the receiver cannot stall, so it must
// take every result in that cycle. A key request (store, erase one, Ctrl-P, Ctrl-O,
// or Ctrl-U with nothing to erase) keeps busy low and its result appears in the cycle
// after acceptance, so keys can follow back to back. A read request with nothing
// committed is answered the same way. Any other read request needs one synchronous
// ring read with registered read data: busy is high for one cycle, and done follows
// once the read data and then the result are registered. Ctrl-U walks the ring backward
// one entry per cycle through the single read port, erasing back to the commit point or
// stopping on a stored line end; done follows in the cycle after the final step.
// The ring needs no clearing after reset. Configuration registers (echo_enable,
// line_buffered, backspace_edit) sit at byte addresses 0, 4, 8 and may be written
// only while no request is in flight.
module console_line_editor_core #(
	parameter int unsigned BUF_DEPTH = cle_pkg::BUF_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [7:0]  key_char,
	input  logic        read_started,
	// result channel
	output logic        done,
	output logic [1:0]  echo_kind,
	output logic [7:0]  echo_char,
	output logic [7:0]  erase_count,
	output logic        line_committed,
	output logic        dump_request,
	output logic        table_mode_now,
	output logic [1:0]  read_status,
	output logic [7:0]  read_char,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Slot address width and index width. Indices run modulo 2*BUF_DEPTH so a full
	// ring and an empty ring are told apart.
	localparam int unsigned AW      = $clog2(BUF_DEPTH);
	localparam int unsigned IW      = AW + 1;
	localparam int unsigned IDX_TOP = 2 * BUF_DEPTH - 1;
	localparam int unsigned IDX_MOD = 2 * BUF_DEPTH;

	typedef logic [IW-1:0] idx_t;
	typedef logic [AW-1:0] slot_t;

	function automatic idx_t idx_inc(input idx_t v);
		return (v == IW'(IDX_TOP)) ? '0 : idx_t'(v + 1'b1);
	endfunction

	function automatic idx_t idx_dec(input idx_t v);
		return (v == '0) ? IW'(IDX_TOP) : idx_t'(v - 1'b1);
	endfunction

	function automatic idx_t idx_dist(input idx_t hi, input idx_t lo);
		logic [IW:0] sum;
		sum = {1'b0, hi} + (IW+1)'(IDX_MOD) - {1'b0, lo};
		return (hi >= lo) ? idx_t'(hi - lo) : sum[IW-1:0];
	endfunction

	function automatic slot_t slot_of(input idx_t v);
		idx_t w;
		w = (v >= IW'(BUF_DEPTH)) ? idx_t'(v - IW'(BUF_DEPTH)) : v;
		return w[AW-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic echo_en_q, line_buf_q, bs_edit_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_en_q  <= 1'b1;
			line_buf_q <= 1'b1;
			bs_edit_q  <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				cle_pkg::REG_ECHO_ENABLE:    echo_en_q  <= pwdata[0];
				cle_pkg::REG_LINE_BUFFERED:  line_buf_q <= pwdata[0];
				cle_pkg::REG_BACKSPACE_EDIT: bs_edit_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			cle_pkg::REG_ECHO_ENABLE:    prdata = {31'b0, echo_en_q};
			cle_pkg::REG_LINE_BUFFERED:  prdata = {31'b0, line_buf_q};
			cle_pkg::REG_BACKSPACE_EDIT: prdata = {31'b0, bs_edit_q};
			default:                     prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Character ring: one write port, one read port, registered read data
	// ---------------------------------------------------------------
	logic [7:0] ring_mem [BUF_DEPTH];
	logic       mem_we, mem_re;
	slot_t      mem_wa, mem_ra;
	logic [7:0] mem_wd;
	logic [7:0] mem_rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= ring_mem[mem_ra];
		end
	end

	// ---------------------------------------------------------------
	// Sequencer state
	// ---------------------------------------------------------------
	cle_pkg::seq_state_t state_q, state_nx;
	idx_t read_q, commit_q, edit_q;
	idx_t read_nx, commit_nx, edit_nx;
	logic table_q, table_nx;
	logic [7:0] erase_cnt_q, erase_cnt_nx;
	logic started_q;
	logic done_q;

	logic accept;
	assign accept = start & ~busy;
	assign busy   = (state_q != cle_pkg::ST_IDLE);

	// result staging
	logic       res_load;
	cle_pkg::echo_kind_t   res_echo_kind;
	logic [7:0] res_echo_char;
	logic [7:0] res_erase;
	logic       res_commit;
	logic       res_dump;
	cle_pkg::read_status_t res_rstat;
	logic [7:0] res_rchar;

	// helpers for the key path
	logic [7:0] key_eff;
	logic       is_erase_key;
	idx_t       edit_dec1, edit_dec2, edit_inc1;
	logic [7:0] erase_sat;

	assign edit_dec1 = idx_dec(edit_q);
	assign edit_dec2 = idx_dec(edit_dec1);
	assign edit_inc1 = idx_inc(edit_q);
	assign erase_sat = (erase_cnt_q == cle_pkg::ERASE_MAX) ? erase_cnt_q
	                                                       : erase_cnt_q + 8'd1;
	assign is_erase_key = (key_char == cle_pkg::KEY_BS) || (key_char == cle_pkg::KEY_DEL);

	always_comb begin
		state_nx      = state_q;
		read_nx       = read_q;
		commit_nx     = commit_q;
		edit_nx       = edit_q;
		table_nx      = table_q;
		erase_cnt_nx  = erase_cnt_q;
		mem_we        = 1'b0;
		mem_wa        = '0;
		mem_wd        = '0;
		mem_re        = 1'b0;
		mem_ra        = '0;
		res_load      = 1'b0;
		res_echo_kind = cle_pkg::ECHO_NONE;
		res_echo_char = '0;
		res_erase     = '0;
		res_commit    = 1'b0;
		res_dump      = 1'b0;
		res_rstat     = cle_pkg::RD_NONE;
		res_rchar     = '0;
		key_eff       = key_char;

		case (state_q)
			cle_pkg::ST_IDLE: begin
				if (accept) begin
					if (operation == cle_pkg::OP_READ) begin
						if (read_q == commit_q) begin
							res_load  = 1'b1;
							res_rstat = cle_pkg::RD_EMPTY;
						end else begin
							mem_re   = 1'b1;
							mem_ra   = slot_of(read_q);
							state_nx = cle_pkg::ST_READ;
						end
					end else if (key_char == cle_pkg::KEY_DUMP) begin
						res_load = 1'b1;
						res_dump = 1'b1;
					end else if (key_char == cle_pkg::KEY_KILL) begin
						erase_cnt_nx = '0;
						if (edit_q == commit_q) begin
							res_load = 1'b1;
						end else begin
							// look at the character just before the edit point
							mem_re   = 1'b1;
							mem_ra   = slot_of(edit_dec1);
							state_nx = cle_pkg::ST_KILL;
						end
					end else if (is_erase_key && bs_edit_q) begin
						res_load = 1'b1;
						if (edit_q != commit_q) begin
							edit_nx       = edit_dec1;
							res_erase     = 8'd1;
							res_echo_kind = cle_pkg::ECHO_ERASE;
						end
					end else begin
						res_load = 1'b1;
						if (key_char == cle_pkg::KEY_TABLE) begin
							table_nx = ~table_q;
							key_eff  = cle_pkg::KEY_NUL;
						end
						if (key_eff == cle_pkg::KEY_CR) begin
							key_eff = cle_pkg::KEY_LF;
						end
						if (!table_nx && key_eff != cle_pkg::KEY_NUL &&
						    {1'b0, idx_dist(edit_q, read_q)} < (IW+1)'(BUF_DEPTH)) begin
							mem_we  = 1'b1;
							mem_wa  = slot_of(edit_q);
							mem_wd  = key_eff;
							edit_nx = edit_inc1;
							if (echo_en_q) begin
								res_echo_kind = cle_pkg::ECHO_CHAR;
								res_echo_char = key_eff;
							end
							// commit on line end, EOF, raw mode or the last free slot
							if (!line_buf_q || key_eff == cle_pkg::KEY_LF ||
							    key_eff == cle_pkg::KEY_EOF ||
							    {1'b0, idx_dist(edit_inc1, read_q)} ==
							    (IW+1)'(BUF_DEPTH)) begin
								commit_nx  = edit_inc1;
								res_commit = 1'b1;
							end
						end
					end
				end
			end

			cle_pkg::ST_READ: begin
				res_load = 1'b1;
				state_nx = cle_pkg::ST_IDLE;
				if (mem_rd_q == cle_pkg::KEY_EOF) begin
					// EOF stays put when the call already returned characters
					res_rstat = cle_pkg::RD_EOF;
					if (!started_q) begin
						read_nx = idx_inc(read_q);
					end
				end else begin
					res_rstat = cle_pkg::RD_CHAR;
					res_rchar = mem_rd_q;
					read_nx   = idx_inc(read_q);
				end
			end

			cle_pkg::ST_KILL: begin
				if (mem_rd_q == cle_pkg::KEY_LF) begin
					res_load      = 1'b1;
					res_erase     = erase_cnt_q;
					res_echo_kind = (erase_cnt_q != '0) ? cle_pkg::ECHO_ERASE
					                                    : cle_pkg::ECHO_NONE;
					state_nx      = cle_pkg::ST_IDLE;
				end else begin
					edit_nx      = edit_dec1;
					erase_cnt_nx = erase_sat;
					if (edit_dec1 == commit_q) begin
						res_load      = 1'b1;
						res_erase     = erase_sat;
						res_echo_kind = cle_pkg::ECHO_ERASE;
						state_nx      = cle_pkg::ST_IDLE;
					end else begin
						mem_re = 1'b1;
						mem_ra = slot_of(edit_dec2);
					end
				end
			end

			default: begin
				state_nx = cle_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cle_pkg::ST_IDLE;
			read_q      <= '0;
			commit_q    <= '0;
			edit_q      <= '0;
			table_q     <= 1'b0;
			erase_cnt_q <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_nx;
			read_q      <= read_nx;
			commit_q    <= commit_nx;
			edit_q      <= edit_nx;
			table_q     <= table_nx;
			erase_cnt_q <= erase_cnt_nx;
			done_q      <= res_load;
		end
	end

	// request and result payload
	logic [1:0] echo_kind_q, read_status_q;
	logic [7:0] echo_char_q, erase_count_q, read_char_q;
	logic       line_committed_q, dump_request_q, table_mode_now_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			started_q <= read_started;
		end
		if (res_load) begin
			echo_kind_q      <= res_echo_kind;
			echo_char_q      <= res_echo_char;
			erase_count_q    <= res_erase;
			line_committed_q <= res_commit;
			dump_request_q   <= res_dump;
			table_mode_now_q <= table_nx;
			read_status_q    <= res_rstat;
			read_char_q      <= res_rchar;
		end
	end

	assign done           = done_q;
	assign echo_kind      = echo_kind_q;
	assign echo_char      = echo_char_q;
	assign erase_count    = erase_count_q;
	assign line_committed = line_committed_q;
	assign dump_request   = dump_request_q;
	assign table_mode_now = table_mode_now_q;
	assign read_status    = read_status_q;
	assign read_char      = read_char_q;

`ifndef ASSERT_OFF
	// commit point always lies between read and edit points, edit at most a ring ahead
	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, idx_dist(edit_q, read_q)} <= (IW+1)'(BUF_DEPTH)) &&
		(idx_dist(commit_q, read_q) <= idx_dist(edit_q, read_q)))
		else $error("ring indices out of order");

	// a result only follows an accepted request or a busy cycle
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result without a request");

	// the kill walk never runs past the commit point
	a_kill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cle_pkg::ST_KILL) |-> (edit_q != commit_q))
		else $error("line kill walked into committed input");
`endif

endmodule
